### design/mev2hid_pkg.sv
package mev2hid_pkg;

  // Event kinds
  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_REL    = 2'd2;
  localparam logic [1:0] KIND_SYNC   = 2'd3;

  // Axis and sync codes
  localparam logic [9:0] CODE_REL_X      = 10'd0;
  localparam logic [9:0] CODE_REL_Y      = 10'd1;
  localparam logic [9:0] CODE_SYN_REPORT = 10'd0;

  // Button codes
  localparam logic [9:0] CODE_BTN_LEFT    = 10'd272;
  localparam logic [9:0] CODE_BTN_RIGHT   = 10'd273;
  localparam logic [9:0] CODE_BTN_MIDDLE  = 10'd274;
  localparam logic [9:0] CODE_BTN_SIDE    = 10'd275;
  localparam logic [9:0] CODE_BTN_EXTRA   = 10'd276;
  localparam logic [9:0] CODE_BTN_FORWARD = 10'd277;
  localparam logic [9:0] CODE_BTN_BACK    = 10'd278;

  localparam int BTN_W  = 5;
  localparam int SENS_W = 14;
  localparam logic [SENS_W-1:0] SENS_MIN   = 14'd3;
  localparam logic [SENS_W-1:0] SENS_MAX   = 14'd8192;
  localparam logic [SENS_W-1:0] SENS_RESET = 14'd256;

  localparam int CHUNK_MAX = 127;
  localparam int MOVE_W    = 8;
  // Holds +-(64*127), the largest total the report count allows
  localparam int TOT_W     = 14;

  localparam int MAX_REPORTS_DEF = 64;
  localparam int SUM_BITS_DEF    = 24;
  localparam int QUEUE_DEPTH     = 4;

  typedef struct packed {
    logic [BTN_W-1:0]        buttons;
    logic signed [TOT_W-1:0] tot_x;
    logic signed [TOT_W-1:0] tot_y;
  } cmd_t;

  function automatic logic [BTN_W-1:0] button_mask(input logic [9:0] code);
    logic [BTN_W-1:0] m;
    unique case (code)
      CODE_BTN_LEFT:                    m = 5'b00001;
      CODE_BTN_RIGHT:                   m = 5'b00010;
      CODE_BTN_MIDDLE:                  m = 5'b00100;
      CODE_BTN_SIDE, CODE_BTN_BACK:     m = 5'b01000;
      CODE_BTN_EXTRA, CODE_BTN_FORWARD: m = 5'b10000;
      default:                          m = 5'b00000;
    endcase
    return m;
  endfunction

endpackage

### design/mouse_event_to_hid_report.sv
// Channel   | Handshake            | Word
// ----------+----------------------+-----------------------------------------
// event in  | push / full          | kind, code, value, forward_enable
// report out| empty / pop          | button_bits, move_x, move_y, last
// config    | sensitivity_we       | sensitivity_q8 (clamped to 3..8192)
//
// A button, motion or ignored event is taken as pushed unless full is high.
// A sync report holds the front while it multiplies X, then Y, on the one
// shared multiplier, rounds both and writes the queue; a button event
// reaches the queue in its accept cycle. The back loads a queued word, then
// emits one report per cycle while they are popped: ceil(max(|tx|,|ty|)/127)
// reports per sync, one per button event. Reset clears buttons, sums, queue
// and output valid flag; no clearing pass. Each half stalls on its own:
// the front on a sync or full queue, the back on a report not yet popped.
module mouse_event_to_hid_report #(
  parameter int MAX_REPORTS = mev2hid_pkg::MAX_REPORTS_DEF,
  parameter int SUM_BITS    = mev2hid_pkg::SUM_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [1:0]                            kind,
  input  logic [9:0]                            code,
  input  logic signed [15:0]                    value,
  input  logic                                  forward_enable,
  input  logic                                  push,
  output logic                                  full,
  output logic [mev2hid_pkg::BTN_W-1:0]         button_bits,
  output logic signed [mev2hid_pkg::MOVE_W-1:0] move_x,
  output logic signed [mev2hid_pkg::MOVE_W-1:0] move_y,
  output logic                                  last,
  output logic                                  empty,
  input  logic                                  pop,
  input  logic                                  sensitivity_we,
  input  logic [mev2hid_pkg::SENS_W-1:0]        sensitivity_q8
);

  logic [mev2hid_pkg::SENS_W-1:0] sens;
  logic [mev2hid_pkg::SENS_W-1:0] sens_next;

  logic              q_push;
  mev2hid_pkg::cmd_t q_wdata;
  logic              q_full;
  logic              q_pop;
  mev2hid_pkg::cmd_t q_rdata;
  logic              q_empty;
  logic              out_valid;

  // Clamp the scale on write so the multiplier sees only legal values
  always_comb begin
    if (sensitivity_q8 < mev2hid_pkg::SENS_MIN) begin
      sens_next = mev2hid_pkg::SENS_MIN;
    end else if (sensitivity_q8 > mev2hid_pkg::SENS_MAX) begin
      sens_next = mev2hid_pkg::SENS_MAX;
    end else begin
      sens_next = sensitivity_q8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sens <= mev2hid_pkg::SENS_RESET;
    end else if (sensitivity_we) begin
      sens <= sens_next;
    end
  end

  // Front: classify events, keep buttons and sums, scale on sync
  mev2hid_front #(
    .MAX_REPORTS (MAX_REPORTS),
    .SUM_BITS    (SUM_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .kind           (kind),
    .code           (code),
    .value          (value),
    .forward_enable (forward_enable),
    .push           (push),
    .full           (full),
    .sens           (sens),
    .q_push         (q_push),
    .q_data         (q_wdata),
    .q_full         (q_full)
  );

  // Short queue of report words between the two halves
  mev2hid_cmd_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .q_empty (q_empty)
  );

  // Back: split each word into 127-step reports into the output register
  mev2hid_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (q_rdata),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_take    (pop),
    .button_bits (button_bits),
    .move_x      (move_x),
    .move_y      (move_y),
    .last        (last)
  );

  assign empty = !out_valid;

endmodule

### design/mev2hid_cmd_fifo.sv
module mev2hid_cmd_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  mev2hid_pkg::cmd_t  wr_data,
  output logic               q_full,
  input  logic               rd_en,
  output mev2hid_pkg::cmd_t  rd_data,
  output logic               q_empty
);

  localparam int DEPTH = mev2hid_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mev2hid_pkg::cmd_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_wr;
  logic do_rd;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### design/mev2hid_front.sv
module mev2hid_front #(
  parameter int MAX_REPORTS = mev2hid_pkg::MAX_REPORTS_DEF,
  parameter int SUM_BITS    = mev2hid_pkg::SUM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        kind,
  input  logic [9:0]                        code,
  input  logic signed [15:0]                value,
  input  logic                              forward_enable,
  input  logic                              push,
  output logic                              full,
  input  logic [mev2hid_pkg::SENS_W-1:0]    sens,
  output logic                              q_push,
  output mev2hid_pkg::cmd_t                 q_data,
  input  logic                              q_full
);

  localparam int PROD_W = SUM_BITS + mev2hid_pkg::SENS_W + 1;
  localparam int RND_W  = PROD_W - 7;
  localparam int TOT_W  = mev2hid_pkg::TOT_W;
  localparam int LIMIT  = MAX_REPORTS * mev2hid_pkg::CHUNK_MAX;

  typedef enum logic [1:0] {ST_IDLE, ST_MULY, ST_RND, ST_PUSH} state_t;

  state_t state;
  logic [mev2hid_pkg::BTN_W-1:0] button_state;
  logic signed [SUM_BITS-1:0] sum_x;
  logic signed [SUM_BITS-1:0] sum_y;
  logic signed [PROD_W-1:0] prod;
  logic signed [TOT_W-1:0] tot_x;
  logic signed [TOT_W-1:0] tot_y;

  logic accept;
  logic take;
  logic is_button;
  logic is_rel_x;
  logic is_rel_y;
  logic is_sync;
  logic [mev2hid_pkg::BTN_W-1:0] mask;
  logic [mev2hid_pkg::BTN_W-1:0] button_next;
  logic signed [SUM_BITS-1:0] add_src;
  logic signed [SUM_BITS-1:0] add_sum;
  logic signed [PROD_W-1:0] mul_a;
  logic signed [PROD_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_out;
  logic push_totals;

  // Saturating add of a signed delta into a SUM_BITS accumulator
  function automatic logic signed [SUM_BITS-1:0] sat_add(
    input logic signed [SUM_BITS-1:0] acc,
    input logic signed [15:0]         delta
  );
    logic signed [SUM_BITS:0] s;
    s = {acc[SUM_BITS-1], acc} + {{(SUM_BITS+1-16){delta[15]}}, delta};
    if (s[SUM_BITS] != s[SUM_BITS-1]) begin
      return s[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end
    return s[SUM_BITS-1:0];
  endfunction

  // Round half away from zero, drop 8 fraction bits, clamp to the report limit
  function automatic logic signed [TOT_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic            neg;
    logic [PROD_W:0] mag;
    logic [RND_W-1:0] q;
    logic [TOT_W-1:0] qc;
    neg = p[PROD_W-1];
    mag = neg ? ((PROD_W+1)'(0) - {p[PROD_W-1], p}) : {1'b0, p};
    mag = mag + (PROD_W+1)'(128);
    q   = mag[PROD_W:8];
    qc  = (q > RND_W'(LIMIT)) ? TOT_W'(LIMIT) : q[TOT_W-1:0];
    return neg ? -$signed(qc) : $signed(qc);
  endfunction

  assign full   = !(state == ST_IDLE && !q_full);
  assign accept = push && !full;
  assign take   = accept && forward_enable;

  assign is_button = take && (kind == mev2hid_pkg::KIND_BUTTON);
  assign is_rel_x  = take && (kind == mev2hid_pkg::KIND_REL) && (code == mev2hid_pkg::CODE_REL_X);
  assign is_rel_y  = take && (kind == mev2hid_pkg::KIND_REL) && (code == mev2hid_pkg::CODE_REL_Y);
  assign is_sync   = take && (kind == mev2hid_pkg::KIND_SYNC)
                     && (code == mev2hid_pkg::CODE_SYN_REPORT);

  assign mask        = mev2hid_pkg::button_mask(code);
  assign button_next = (value != 16'sd0) ? (button_state | mask) : (button_state & ~mask);

  assign add_src = is_rel_y ? sum_y : sum_x;
  assign add_sum = sat_add(add_src, value);

  // One shared multiplier: X on the accept cycle, Y on the next
  assign mul_a   = (state == ST_IDLE) ? PROD_W'(sum_x) : PROD_W'(sum_y);
  assign mul_b   = $signed({{(PROD_W-mev2hid_pkg::SENS_W){1'b0}}, sens});
  assign mul_out = mul_a * mul_b;

  assign push_totals = (state == ST_PUSH) && ((tot_x != '0) || (tot_y != '0)) && !q_full;

  always_comb begin
    q_push = is_button || push_totals;
    if (state == ST_PUSH) begin
      q_data = '{buttons: button_state, tot_x: tot_x, tot_y: tot_y};
    end else begin
      q_data = '{buttons: button_next, tot_x: '0, tot_y: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      button_state <= '0;
      sum_x        <= '0;
      sum_y        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (is_button) begin
            button_state <= button_next;
          end
          if (is_rel_x) begin
            sum_x <= add_sum;
          end
          if (is_rel_y) begin
            sum_y <= add_sum;
          end
          if (is_sync) begin
            prod  <= mul_out;
            state <= ST_MULY;
          end
        end
        ST_MULY: begin
          tot_x <= round_sat(prod);
          prod  <= mul_out;
          state <= ST_RND;
        end
        ST_RND: begin
          tot_y <= round_sat(prod);
          sum_x <= '0;
          sum_y <= '0;
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          // Zero totals give no report; otherwise hold until the queue has room
          if ((tot_x == '0 && tot_y == '0) || !q_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/mev2hid_back.sv
module mev2hid_back (
  input  logic                              clk,
  input  logic                              rst,
  input  mev2hid_pkg::cmd_t                 q_data,
  input  logic                              q_empty,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_take,
  output logic [mev2hid_pkg::BTN_W-1:0]     button_bits,
  output logic signed [mev2hid_pkg::MOVE_W-1:0] move_x,
  output logic signed [mev2hid_pkg::MOVE_W-1:0] move_y,
  output logic                              last
);

  localparam int TOT_W  = mev2hid_pkg::TOT_W;
  localparam int MOVE_W = mev2hid_pkg::MOVE_W;

  logic busy;
  logic [mev2hid_pkg::BTN_W-1:0] buttons;
  logic signed [TOT_W-1:0] rem_x;
  logic signed [TOT_W-1:0] rem_y;

  logic emit;
  logic signed [TOT_W-1:0] chunk_x;
  logic signed [TOT_W-1:0] chunk_y;
  logic signed [TOT_W-1:0] rem_x_next;
  logic signed [TOT_W-1:0] rem_y_next;
  logic done;

  function automatic logic signed [TOT_W-1:0] clamp_chunk(input logic signed [TOT_W-1:0] t);
    if (t > TOT_W'(mev2hid_pkg::CHUNK_MAX)) begin
      return TOT_W'(mev2hid_pkg::CHUNK_MAX);
    end
    if (t < -TOT_W'(mev2hid_pkg::CHUNK_MAX)) begin
      return -TOT_W'(mev2hid_pkg::CHUNK_MAX);
    end
    return t;
  endfunction

  assign q_pop      = !busy && !q_empty;
  assign emit       = busy && (!out_valid || out_take);
  assign chunk_x    = clamp_chunk(rem_x);
  assign chunk_y    = clamp_chunk(rem_y);
  assign rem_x_next = rem_x - chunk_x;
  assign rem_y_next = rem_y - chunk_y;
  // A button word carries zero totals, so it ends after one report
  assign done       = (rem_x_next == '0) && (rem_y_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy    <= 1'b1;
        buttons <= q_data.buttons;
        rem_x   <= q_data.tot_x;
        rem_y   <= q_data.tot_y;
      end else if (emit) begin
        rem_x <= rem_x_next;
        rem_y <= rem_y_next;
        if (done) begin
          busy <= 1'b0;
        end
      end
      if (emit) begin
        out_valid   <= 1'b1;
        button_bits <= buttons;
        move_x      <= chunk_x[MOVE_W-1:0];
        move_y      <= chunk_y[MOVE_W-1:0];
        last        <= done;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_move_x_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> move_x != -8'sd128)
    else $error("move_x out of report range");
  a_move_y_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> move_y != -8'sd128)
    else $error("move_y out of report range");
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> busy)
    else $error("report without last but no word in progress");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> busy)
    else $error("popped word not taken up");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int BTN_W  = mev2hid_pkg::BTN_W;
  localparam int SENS_W = mev2hid_pkg::SENS_W;
  localparam int MOVE_W = mev2hid_pkg::MOVE_W;
  localparam longint CHUNK_MAX   = mev2hid_pkg::CHUNK_MAX;
  localparam int     MAX_REPORTS = mev2hid_pkg::MAX_REPORTS_DEF;

  // Idle time before a sensitivity write: covers a sync still in the front
  // that leaves no report behind it.
  localparam int SETTLE_CYCLES  = 20;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  // Steps of +32767 that carry a 24-bit sum just past its top
  localparam int SAT_STEPS      = 257;
  localparam longint SUM_HI     = (64'sd1 <<< (mev2hid_pkg::SUM_BITS_DEF - 1)) - 1;
  localparam longint SUM_LO     = -SUM_HI - 1;
  localparam longint TOTAL_CAP  = MAX_REPORTS * CHUNK_MAX;

  typedef struct packed {
    logic [BTN_W-1:0]         buttons;
    logic signed [MOVE_W-1:0] dx;
    logic signed [MOVE_W-1:0] dy;
    logic                     fin;
  } hid_report_t;

  logic                     clk;
  logic                     rst;
  logic [1:0]               kind;
  logic [9:0]               code;
  logic signed [15:0]       value;
  logic                     forward_enable;
  logic                     push;
  logic                     full;
  logic [BTN_W-1:0]         button_bits;
  logic signed [MOVE_W-1:0] move_x;
  logic signed [MOVE_W-1:0] move_y;
  logic                     last;
  logic                     empty;
  logic                     pop;
  logic                     sensitivity_we;
  logic [SENS_W-1:0]        sensitivity_q8;

  // Predictor state: what the block should hold after every accepted word
  logic [BTN_W-1:0]  buttons_held = '0;
  longint            acc_x = 0;
  longint            acc_y = 0;
  logic [SENS_W-1:0] sens_written = mev2hid_pkg::SENS_RESET;
  hid_report_t       pending_reports[$];

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  bit long_hold_req = 0;
  int words_in      = 0;
  int reports_seen  = 0;
  int syncs_sent    = 0;
  int mismatches    = 0;
  int idle_cycles   = 0;
  hid_report_t want;

  mouse_event_to_hid_report dut (
    .clk            (clk),
    .rst            (rst),
    .kind           (kind),
    .code           (code),
    .value          (value),
    .forward_enable (forward_enable),
    .push           (push),
    .full           (full),
    .button_bits    (button_bits),
    .move_x         (move_x),
    .move_y         (move_y),
    .last           (last),
    .empty          (empty),
    .pop            (pop),
    .sensitivity_we (sensitivity_we),
    .sensitivity_q8 (sensitivity_q8)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Add a delta and pin the sum to the accumulator's two's complement range.
  function automatic longint add_clipped(input longint acc, input longint delta);
    longint s;
    s = acc + delta;
    if (s > SUM_HI) return SUM_HI;
    if (s < SUM_LO) return SUM_LO;
    return s;
  endfunction

  // Scale by the Q6.8 factor, round half away from zero, cap the magnitude.
  function automatic longint scaled(input longint sum, input longint sens);
    longint p, mag, q;
    p   = sum * sens;
    mag = (p < 0) ? -p : p;
    q   = (mag + 128) >> 8;
    if (q > TOTAL_CAP) q = TOTAL_CAP;
    return (p < 0) ? -q : q;
  endfunction

  function automatic longint clip_chunk(input longint t);
    if (t > CHUNK_MAX) return CHUNK_MAX;
    if (t < -CHUNK_MAX) return -CHUNK_MAX;
    return t;
  endfunction

  // Advance the predictor by one accepted word and queue the reports it causes.
  task automatic apply_event(input logic [1:0] k, input logic [9:0] c,
                             input logic signed [15:0] v, input logic f);
    logic [BTN_W-1:0] hit;
    longint eff, tx, ty, cx, cy;
    int n;
    hid_report_t r;
    if (!f) return;
    case (k)
      mev2hid_pkg::KIND_BUTTON: begin
        case (c)
          mev2hid_pkg::CODE_BTN_LEFT:   hit = 5'b00001;
          mev2hid_pkg::CODE_BTN_RIGHT:  hit = 5'b00010;
          mev2hid_pkg::CODE_BTN_MIDDLE: hit = 5'b00100;
          mev2hid_pkg::CODE_BTN_SIDE,
          mev2hid_pkg::CODE_BTN_BACK:   hit = 5'b01000;
          mev2hid_pkg::CODE_BTN_EXTRA,
          mev2hid_pkg::CODE_BTN_FORWARD: hit = 5'b10000;
          default:                      hit = 5'b00000;
        endcase
        if (v != 0) buttons_held = buttons_held | hit;
        else buttons_held = buttons_held & ~hit;
        // Unknown codes still produce a zero-motion report
        r.buttons = buttons_held;
        r.dx = '0;
        r.dy = '0;
        r.fin = 1'b1;
        pending_reports.push_back(r);
      end
      mev2hid_pkg::KIND_REL: begin
        if (c == mev2hid_pkg::CODE_REL_X) acc_x = add_clipped(acc_x, longint'(v));
        else if (c == mev2hid_pkg::CODE_REL_Y) acc_y = add_clipped(acc_y, longint'(v));
      end
      mev2hid_pkg::KIND_SYNC: begin
        if (c == mev2hid_pkg::CODE_SYN_REPORT) begin
          // The block clamps the register on write; clamping here at use gives the same scale
          if (sens_written < mev2hid_pkg::SENS_MIN) eff = longint'(mev2hid_pkg::SENS_MIN);
          else if (sens_written > mev2hid_pkg::SENS_MAX) eff = longint'(mev2hid_pkg::SENS_MAX);
          else eff = longint'(sens_written);
          tx = scaled(acc_x, eff);
          ty = scaled(acc_y, eff);
          n = 0;
          while ((tx != 0 || ty != 0) && n < MAX_REPORTS) begin
            cx = clip_chunk(tx);
            cy = clip_chunk(ty);
            tx -= cx;
            ty -= cy;
            r.buttons = buttons_held;
            r.dx = cx[MOVE_W-1:0];
            r.dy = cy[MOVE_W-1:0];
            r.fin = (tx == 0 && ty == 0) || (n == MAX_REPORTS - 1);
            pending_reports.push_back(r);
            n++;
          end
          acc_x = 0;
          acc_y = 0;
        end
      end
      default: ;
    endcase
  endtask

  // Offer one word after a random gap; hold it until the block takes it.
  task automatic send_word(input logic [1:0] k, input logic [9:0] c,
                           input logic signed [15:0] v, input logic f);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    kind = k;
    code = c;
    value = v;
    forward_enable = f;
    push = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    apply_event(k, c, v, f);
    words_in++;
    if (k == mev2hid_pkg::KIND_SYNC) syncs_sent++;
  endtask

  // Drop push, wait for every expected report, then let the front settle.
  task automatic drain_reports();
    @(negedge clk);
    push = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_sensitivity(input logic [SENS_W-1:0] s);
    drain_reports();
    sensitivity_we = 1'b1;
    sensitivity_q8 = s;
    @(negedge clk);
    sensitivity_we = 1'b0;
    sens_written = s;
  endtask

  // Words the block must ignore or that carry a random, mostly unmapped code.
  task automatic send_noise_word();
    case ($urandom_range(4))
      0: send_word(mev2hid_pkg::KIND_OTHER, 10'($urandom_range(767)), 16'($urandom),
                   1'($urandom_range(1)));
      1: send_word(2'($urandom_range(3)), 10'($urandom_range(767)), 16'($urandom), 1'b0);
      2: send_word(mev2hid_pkg::KIND_BUTTON, 10'($urandom_range(767)), 16'($urandom),
                   1'b1);
      3: send_word(mev2hid_pkg::KIND_REL, 10'($urandom_range(2, 767)), 16'($urandom),
                   1'b1);
      default: send_word(mev2hid_pkg::KIND_SYNC, 10'($urandom_range(1, 767)),
                         16'($urandom), 1'b1);
    endcase
  endtask

  // A well-formed frame: a few motion deltas, maybe a button, then a sync.
  task automatic send_motion_burst(output int words);
    int moves;
    logic signed [15:0] v;
    moves = int'($urandom_range(4));
    words = moves + 1;
    repeat (moves) begin
      if ($urandom_range(7) == 0) v = 16'($urandom);
      else v = 16'(int'($urandom_range(600)) - 300);
      send_word(mev2hid_pkg::KIND_REL,
                $urandom_range(1) ? mev2hid_pkg::CODE_REL_Y : mev2hid_pkg::CODE_REL_X,
                v, 1'b1);
    end
    if ($urandom_range(3) == 0) begin
      send_word(mev2hid_pkg::KIND_BUTTON,
                10'(mev2hid_pkg::CODE_BTN_LEFT + $urandom_range(6)),
                $urandom_range(1) ? 16'sd0 : 16'($urandom_range(1, 65535)), 1'b1);
      words++;
    end
    send_word(mev2hid_pkg::KIND_SYNC, mev2hid_pkg::CODE_SYN_REPORT, 16'($urandom), 1'b1);
  endtask

  // Every button code, unknown code, ignored words, motion extremes and
  // a sync that hits the report cap, all at the reset sensitivity.
  task automatic test_directed_events();
    send_word(mev2hid_pkg::KIND_BUTTON, mev2hid_pkg::CODE_BTN_LEFT, 16'sd1, 1'b1);
    send_word(mev2hid_pkg::KIND_BUTTON, mev2hid_pkg::CODE_BTN_RIGHT, -16'sd32768, 1'b1);
    send_word(mev2hid_pkg::KIND_BUTTON, mev2hid_pkg::CODE_BTN_MIDDLE, 16'sd32767, 1'b1);
    send_word(mev2hid_pkg::KIND_BUTTON, mev2hid_pkg::CODE_BTN_SIDE, 16'sd1, 1'b1);
    send_word(mev2hid_pkg::KIND_BUTTON, mev2hid_pkg::CODE_BTN_FORWARD, 16'sd1, 1'b1);
    send_word(mev2hid_pkg::KIND_BUTTON, mev2hid_pkg::CODE_BTN_BACK, 16'sd0, 1'b1);
    send_word(mev2hid_pkg::KIND_BUTTON, mev2hid_pkg::CODE_BTN_EXTRA, 16'sd0, 1'b1);
    send_word(mev2hid_pkg::KIND_BUTTON, 10'd767, 16'sd1, 1'b1);
    send_word(mev2hid_pkg::KIND_OTHER, mev2hid_pkg::CODE_BTN_LEFT, 16'sd1, 1'b1);
    send_word(mev2hid_pkg::KIND_BUTTON, mev2hid_pkg::CODE_BTN_LEFT, 16'sd0, 1'b0);
    send_word(mev2hid_pkg::KIND_REL, mev2hid_pkg::CODE_REL_X, 16'sd32767, 1'b1);
    send_word(mev2hid_pkg::KIND_REL, mev2hid_pkg::CODE_REL_Y, -16'sd32768, 1'b1);
    send_word(mev2hid_pkg::KIND_REL, 10'd2, 16'sd1000, 1'b1);
    send_word(mev2hid_pkg::KIND_SYNC, 10'd1, 16'sd0, 1'b1);
    send_word(mev2hid_pkg::KIND_SYNC, mev2hid_pkg::CODE_SYN_REPORT, 16'sd0, 1'b1);
    send_word(mev2hid_pkg::KIND_SYNC, mev2hid_pkg::CODE_SYN_REPORT, 16'sd0, 1'b1);
  endtask

  // Half a count at 0.5x: rounds away from zero on both signs.
  task automatic test_rounding();
    write_sensitivity(14'd128);
    send_word(mev2hid_pkg::KIND_REL, mev2hid_pkg::CODE_REL_X, 16'sd1, 1'b1);
    send_word(mev2hid_pkg::KIND_REL, mev2hid_pkg::CODE_REL_Y, -16'sd1, 1'b1);
    send_word(mev2hid_pkg::KIND_SYNC, mev2hid_pkg::CODE_SYN_REPORT, 16'sd0, 1'b1);
    send_word(mev2hid_pkg::KIND_REL, mev2hid_pkg::CODE_REL_X, 16'sd3, 1'b1);
    send_word(mev2hid_pkg::KIND_REL, mev2hid_pkg::CODE_REL_Y, -16'sd255, 1'b1);
    send_word(mev2hid_pkg::KIND_SYNC, mev2hid_pkg::CODE_SYN_REPORT, 16'sd0, 1'b1);
  endtask

  // Drive X just past the top of the accumulator at the lowest sensitivity;
  // a sum that wrapped instead of clipping would flip the capped report sign.
  task automatic test_accumulator_saturation();
    write_sensitivity(mev2hid_pkg::SENS_MIN);
    send_idle_pct = 0;
    pop_stall_pct = 0;
    repeat (SAT_STEPS)
      send_word(mev2hid_pkg::KIND_REL, mev2hid_pkg::CODE_REL_X, 16'sd32767, 1'b1);
    send_word(mev2hid_pkg::KIND_REL, mev2hid_pkg::CODE_REL_Y, -16'sd32768, 1'b1);
    send_word(mev2hid_pkg::KIND_SYNC, mev2hid_pkg::CODE_SYN_REPORT, 16'sd0, 1'b1);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [SENS_W-1:0] sens,
                                     input int words_wanted);
    int done, n;
    write_sensitivity(sens);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    done = 0;
    while (done < words_wanted) begin
      if ($urandom_range(4) == 0) begin
        send_noise_word();
      end else begin
        send_motion_burst(n);
        done += n;
      end
    end
  endtask

  // Hold the receiver off long enough that the report queue fills and the
  // front has to stall while words keep coming.
  task automatic test_backpressure();
    drain_reports();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    long_hold_req = 1'b1;
    repeat (16)
      send_word(mev2hid_pkg::KIND_BUTTON,
                10'(mev2hid_pkg::CODE_BTN_LEFT + $urandom_range(6)), 16'($urandom), 1'b1);
    send_word(mev2hid_pkg::KIND_REL, mev2hid_pkg::CODE_REL_X, -16'sd2000, 1'b1);
    send_word(mev2hid_pkg::KIND_REL, mev2hid_pkg::CODE_REL_Y, 16'sd1500, 1'b1);
    send_word(mev2hid_pkg::KIND_SYNC, mev2hid_pkg::CODE_SYN_REPORT, 16'sd0, 1'b1);
  endtask

  // Receiver: random stalls, or one long hold-off on request.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        pop = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        pop = ($urandom_range(99) < pop_stall_pct) ? 1'b0 : 1'b1;
      end
    end
  end

  // Compare each popped report with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: report with nothing expected: btn=%0h dx=%0d dy=%0d last=%0b",
                   $time, button_bits, move_x, move_y, last);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if ({button_bits, move_x, move_y, last} !== want) begin
          if (mismatches < 10) begin
            $display("%0t: report mismatch: want btn=%0h dx=%0d dy=%0d last=%0b,",
                     $time, want.buttons, want.dx, want.dy, want.fin);
            $display("    got btn=%0h dx=%0d dy=%0d last=%0b",
                     button_bits, move_x, move_y, last);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long with no handshake on either side ends the run.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d reports outstanding",
               idle_cycles, pending_reports.size());
      $display("mouse_event_to_hid_report regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    kind = mev2hid_pkg::KIND_OTHER;
    code = '0;
    value = '0;
    forward_enable = 1'b0;
    sensitivity_we = 1'b0;
    sensitivity_q8 = mev2hid_pkg::SENS_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_events();
    test_rounding();
    test_accumulator_saturation();
    test_random_traffic(0, 0, mev2hid_pkg::SENS_MAX, 8);
    test_random_traffic(63, 0, 14'd0, 8);
    test_random_traffic(0, 63, 14'h3FFF, 8);
    test_random_traffic(26, 26,
                        SENS_W'($urandom_range(mev2hid_pkg::SENS_MIN, mev2hid_pkg::SENS_MAX)),
                        8);
    test_backpressure();
    drain_reports();

    $display("covered %0d input words (%0d syncs) and checked %0d reports", words_in,
             syncs_sent, reports_seen);
    $display("sensitivity at reset, 0.5x, both clamp limits and beyond, random;");
    $display("X sum clipped at its top, long pop hold-off");
    if (mismatches == 0)
      $display("mouse_event_to_hid_report regression: pass");
    else
      $display("mouse_event_to_hid_report regression: fail");
    $finish;
  end

endmodule
